// ----- design/tsp_three_opt_path_improver_defines.svh -----
// Assertion macros for the 3-opt path improver.
`ifndef TSP_THREE_OPT_PATH_IMPROVER_DEFINES_SVH
`define TSP_THREE_OPT_PATH_IMPROVER_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define TTO_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define TTO_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- design/tto_pkg.sv -----
// Types and constants shared by the 3-opt path improver.
`timescale 1ns / 1ps
package tto_pkg;

  localparam int unsigned MAX_POINTS     = 64;
  localparam int unsigned COORD_W        = 16;
  localparam int unsigned CITY_W         = 6;
  localparam int unsigned LEN_W          = 31;
  localparam int unsigned DIST_W         = 25;
  localparam int unsigned SQ_W           = 33;
  localparam int unsigned RAD_W          = 50;
  localparam int unsigned REM_W          = 28;
  localparam int unsigned MIN_OPT_POINTS = 10;
  localparam logic [LEN_W-1:0] LEN_MAX   = {LEN_W{1'b1}};

  typedef struct packed {
    logic [COORD_W-1:0] x_coord;
    logic [COORD_W-1:0] y_coord;
    logic               last_point;
  } in_t;

  typedef struct packed {
    logic [CITY_W-1:0] city_index;
    logic [LEN_W-1:0]  path_length;
    logic              last_city;
  } out_t;

  // Reconnections of segments S1 S2 S3 S4 (~ = reversed).
  typedef enum logic [2:0] {
    RC_IDENT,     // S1 S2 S3 S4
    RC_REV2,      // S1 ~S2 S3 S4
    RC_REV3,      // S1 S2 ~S3 S4
    RC_REV23,     // S1 ~S2 ~S3 S4
    RC_SWAP,      // S1 S3 S2 S4
    RC_SWAP_REV3, // S1 ~S3 S2 S4
    RC_MOVE4,     // S1 S2 S4 S3
    RC_ROTATE     // S1 S4 S3 S2
  } recon_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DB_ADDR,
    S_DB_SQX,
    S_DB_SQY,
    S_DB_SQRT,
    S_INIT,
    S_EV_ADDR,
    S_EV_TOUR,
    S_EV_DIST,
    S_EV_DONE,
    S_RB_ADDR,
    S_RB_WR,
    S_CB_ADDR,
    S_CB_WR,
    S_EM_ADDR,
    S_EM_SEND
  } state_e;

endpackage

// ----- design/tsp_three_opt_path_improver.sv -----
// Top level of the 3-opt open-path improver: load, distance table, search, emit.
`timescale 1ns / 1ps
`include "tsp_three_opt_path_improver_defines.svh"

// Points load one per cycle while busy is low (start high, busy low accepts a
// transaction). A point marked last_point starts the run: busy rises and stays
// high until the tour has been emitted. The distance table is built over the
// n*n ordered pairs with one shared 16x16 multiplier used twice per pair, then
// a square root that retires one result bit per cycle. Scoring one candidate
// walks the n tour positions through the tour memory and distance memory; a
// pass scores all 8 reconnections of every cut triple, and an improved tour is
// adopted by copying it through the candidate memory back to the tour memory.
// Passes repeat until one gains nothing; the number of passes is data
// dependent. The tour then leaves as n result transactions, each on result_o
// for exactly one cycle with result_valid_o high. The receiver cannot stall;
// it must take every strobe. Fewer than ten points skip the search and return
// the identity order with its length.
module tsp_three_opt_path_improver (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start,
  output logic          busy,
  input  tto_pkg::in_t  item_i,
  output logic          result_valid_o,
  output tto_pkg::out_t result_o
);

  localparam int unsigned IW = $clog2(tto_pkg::MAX_POINTS);
  localparam int unsigned CW = $clog2(tto_pkg::MAX_POINTS + 1);

  // Memories
  logic [31:0]                 point_mem [tto_pkg::MAX_POINTS];
  logic [tto_pkg::DIST_W-1:0]  dist_mem  [tto_pkg::MAX_POINTS*tto_pkg::MAX_POINTS];
  logic [IW-1:0]               tour_mem  [tto_pkg::MAX_POINTS];
  logic [IW-1:0]               cand_mem  [tto_pkg::MAX_POINTS];

  tto_pkg::state_e state_q, state_d;

  logic [CW-1:0] count_q, count_d, n_q, n_d;
  logic [IW-1:0] a_q, a_d, b_q, b_d;
  logic [IW-1:0] p_q, p_d, prev_q, prev_d;
  logic [IW-1:0] i_q, i_d, j_q, j_d, k_q, k_d;
  logic [IW-1:0] bi_q, bi_d, bj_q, bj_d, bk_q, bk_d;
  tto_pkg::recon_e c_q, c_d, bc_q, bc_d;
  logic first_q, first_d, improved_q, improved_d;
  logic [tto_pkg::LEN_W-1:0] acc_q, acc_d, best_q, best_d;

  logic [31:0]                pa_q, pb_q;
  logic [tto_pkg::COORD_W-1:0] ady_q, ady_d;
  logic [tto_pkg::SQ_W-1:0]   sum_q, sum_d;
  logic [tto_pkg::RAD_W-1:0]  rad_q, rad_d;
  logic [tto_pkg::REM_W-1:0]  rem_q, rem_d;
  logic [tto_pkg::DIST_W-1:0] root_q, root_d;
  logic [4:0]                 it_q, it_d;

  logic [IW-1:0]              tour_raddr, tour_rdata_q, tour_waddr, tour_wdata;
  logic                       tour_we;
  logic [IW-1:0]              cand_rdata_q;
  logic                       cand_we;
  logic [2*IW-1:0]            dist_raddr;
  logic [tto_pkg::DIST_W-1:0] dist_rdata_q;
  logic                       dist_we;
  logic                       point_we;

  tto_pkg::out_t result_q, result_d;
  logic          valid_q, valid_d;

  logic accept;
  logic [tto_pkg::COORD_W-1:0] mul_a;
  logic [31:0]                 mul_p;
  logic [tto_pkg::COORD_W-1:0] adx, ady_now;
  logic [tto_pkg::REM_W-1:0]   rem_sh, trial;
  logic                        sq_ge;
  logic [31:0]                 acc_sum;
  logic [tto_pkg::LEN_W-1:0]   acc_sat;
  logic                        better, pass_end, imp_next;

  // Source position in the current tour of candidate position p.
  function automatic logic [IW-1:0] map_pos(tto_pkg::recon_e c, logic [IW-1:0] i,
                                            logic [IW-1:0] j, logic [IW-1:0] k,
                                            logic [IW-1:0] p, logic [CW-1:0] n);
    logic [CW-1:0] ci, cj, ck, cp, q, l0, l1, off, src;
    logic [CW-1:0] lo0, hi0, lo1, hi1, lo2, hi2;
    logic rv0, rv1, rv2;
    ci = CW'(i); cj = CW'(j); ck = CW'(k); cp = CW'(p);
    lo0 = ci; hi0 = cj; rv0 = 1'b0;
    lo1 = cj; hi1 = ck; rv1 = 1'b0;
    lo2 = ck; hi2 = n;  rv2 = 1'b0;
    unique case (c)
      tto_pkg::RC_IDENT: begin
      end
      tto_pkg::RC_REV2: rv0 = 1'b1;
      tto_pkg::RC_REV3: rv1 = 1'b1;
      tto_pkg::RC_REV23: begin
        rv0 = 1'b1; rv1 = 1'b1;
      end
      tto_pkg::RC_SWAP: begin
        lo0 = cj; hi0 = ck; lo1 = ci; hi1 = cj;
      end
      tto_pkg::RC_SWAP_REV3: begin
        lo0 = cj; hi0 = ck; rv0 = 1'b1; lo1 = ci; hi1 = cj;
      end
      tto_pkg::RC_MOVE4: begin
        lo1 = ck; hi1 = n; lo2 = cj; hi2 = ck;
      end
      tto_pkg::RC_ROTATE: begin
        lo0 = ck; hi0 = n; lo1 = cj; hi1 = ck; lo2 = ci; hi2 = cj;
      end
      default: begin
      end
    endcase
    q  = cp - ci;
    l0 = hi0 - lo0;
    l1 = hi1 - lo1;
    priority if (cp < ci) begin
      src = cp;
    end else if (q < l0) begin
      src = rv0 ? (hi0 - CW'(1) - q) : (lo0 + q);
    end else if (q < l0 + l1) begin
      off = q - l0;
      src = rv1 ? (hi1 - CW'(1) - off) : (lo1 + off);
    end else begin
      off = q - l0 - l1;
      src = rv2 ? (hi2 - CW'(1) - off) : (lo2 + off);
    end
    return src[IW-1:0];
  endfunction

  assign accept = start && !busy;
  assign busy   = (state_q != tto_pkg::S_IDLE);

  // Shared multiplier and square-root step
  assign adx     = (pa_q[31:16] >= pb_q[31:16]) ? (pa_q[31:16] - pb_q[31:16])
                                                 : (pb_q[31:16] - pa_q[31:16]);
  assign ady_now = (pa_q[15:0] >= pb_q[15:0]) ? (pa_q[15:0] - pb_q[15:0])
                                               : (pb_q[15:0] - pa_q[15:0]);
  assign mul_a   = (state_q == tto_pkg::S_DB_SQX) ? adx : ady_q;
  assign mul_p   = 32'(mul_a) * 32'(mul_a);

  assign rem_sh = {rem_q[tto_pkg::REM_W-3:0], rad_q[tto_pkg::RAD_W-1 -: 2]};
  assign trial  = {1'b0, root_q, 2'b01};
  assign sq_ge  = (rem_sh >= trial);

  // Saturating path accumulation
  assign acc_sum = {1'b0, acc_q} + 32'(dist_rdata_q);
  assign acc_sat = (acc_sum > 32'(tto_pkg::LEN_MAX)) ? tto_pkg::LEN_MAX
                                                     : acc_sum[tto_pkg::LEN_W-1:0];
  assign better  = (acc_q < best_q);

  assign pass_end = (c_q == tto_pkg::RC_ROTATE) && (CW'(k_q) == n_q - CW'(2)) &&
                    (CW'(j_q) == n_q - CW'(4)) && (CW'(i_q) == n_q - CW'(5));
  assign imp_next = improved_q || better;

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      tto_pkg::S_IDLE: begin
        if (accept && item_i.last_point) state_d = tto_pkg::S_DB_ADDR;
      end
      tto_pkg::S_DB_ADDR: state_d = tto_pkg::S_DB_SQX;
      tto_pkg::S_DB_SQX:  state_d = tto_pkg::S_DB_SQY;
      tto_pkg::S_DB_SQY:  state_d = tto_pkg::S_DB_SQRT;
      tto_pkg::S_DB_SQRT: begin
        if (it_q == 5'(tto_pkg::DIST_W - 1)) begin
          if (CW'(a_q) == n_q - CW'(1) && CW'(b_q) == n_q - CW'(1)) begin
            state_d = tto_pkg::S_INIT;
          end else begin
            state_d = tto_pkg::S_DB_ADDR;
          end
        end
      end
      tto_pkg::S_INIT: begin
        if (CW'(p_q) == n_q - CW'(1)) state_d = tto_pkg::S_EV_ADDR;
      end
      tto_pkg::S_EV_ADDR: state_d = tto_pkg::S_EV_TOUR;
      tto_pkg::S_EV_TOUR: begin
        if (p_q != '0)                    state_d = tto_pkg::S_EV_DIST;
        else if (n_q == CW'(1))           state_d = tto_pkg::S_EV_DONE;
        else                              state_d = tto_pkg::S_EV_ADDR;
      end
      tto_pkg::S_EV_DIST: begin
        if (CW'(p_q) == n_q - CW'(1)) state_d = tto_pkg::S_EV_DONE;
        else                          state_d = tto_pkg::S_EV_ADDR;
      end
      tto_pkg::S_EV_DONE: begin
        if (first_q) begin
          state_d = (n_q < CW'(tto_pkg::MIN_OPT_POINTS)) ? tto_pkg::S_EM_ADDR
                                                         : tto_pkg::S_EV_ADDR;
        end else if (pass_end) begin
          state_d = imp_next ? tto_pkg::S_RB_ADDR : tto_pkg::S_EM_ADDR;
        end else begin
          state_d = tto_pkg::S_EV_ADDR;
        end
      end
      tto_pkg::S_RB_ADDR: state_d = tto_pkg::S_RB_WR;
      tto_pkg::S_RB_WR: begin
        state_d = (CW'(p_q) == n_q - CW'(1)) ? tto_pkg::S_CB_ADDR : tto_pkg::S_RB_ADDR;
      end
      tto_pkg::S_CB_ADDR: state_d = tto_pkg::S_CB_WR;
      tto_pkg::S_CB_WR: begin
        state_d = (CW'(p_q) == n_q - CW'(1)) ? tto_pkg::S_EV_ADDR : tto_pkg::S_CB_ADDR;
      end
      tto_pkg::S_EM_ADDR: state_d = tto_pkg::S_EM_SEND;
      tto_pkg::S_EM_SEND: begin
        state_d = (CW'(p_q) == n_q - CW'(1)) ? tto_pkg::S_IDLE : tto_pkg::S_EM_ADDR;
      end
      default: state_d = tto_pkg::S_IDLE;
    endcase
  end

  // Datapath and memory controls
  always_comb begin
    count_d = count_q; n_d = n_q; a_d = a_q; b_d = b_q;
    p_d = p_q; prev_d = prev_q;
    i_d = i_q; j_d = j_q; k_d = k_q; c_d = c_q;
    bi_d = bi_q; bj_d = bj_q; bk_d = bk_q; bc_d = bc_q;
    first_d = first_q; improved_d = improved_q;
    acc_d = acc_q; best_d = best_q;
    ady_d = ady_q; sum_d = sum_q; rad_d = rad_q; rem_d = rem_q;
    root_d = root_q; it_d = it_q;
    tour_raddr = p_q; tour_we = 1'b0; tour_waddr = p_q; tour_wdata = p_q;
    cand_we = 1'b0; dist_we = 1'b0; point_we = 1'b0;
    dist_raddr = {prev_q, tour_rdata_q};
    result_d = result_q; valid_d = 1'b0;

    unique case (state_q)
      tto_pkg::S_IDLE: begin
        if (accept) begin
          if (count_q < CW'(tto_pkg::MAX_POINTS)) begin
            point_we = 1'b1;
            count_d  = count_q + CW'(1);
          end
          if (item_i.last_point) begin
            n_d = count_d;
            a_d = '0;
            b_d = '0;
          end
        end
      end
      tto_pkg::S_DB_ADDR: begin
      end
      tto_pkg::S_DB_SQX: begin
        ady_d = ady_now;
        sum_d = tto_pkg::SQ_W'(mul_p);
      end
      tto_pkg::S_DB_SQY: begin
        sum_d  = sum_q + tto_pkg::SQ_W'(mul_p);
        rad_d  = {1'b0, sum_d, 16'b0};
        rem_d  = '0;
        root_d = '0;
        it_d   = '0;
      end
      tto_pkg::S_DB_SQRT: begin
        rad_d = {rad_q[tto_pkg::RAD_W-3:0], 2'b00};
        if (sq_ge) begin
          rem_d  = rem_sh - trial;
          root_d = {root_q[tto_pkg::DIST_W-2:0], 1'b1};
        end else begin
          rem_d  = rem_sh;
          root_d = {root_q[tto_pkg::DIST_W-2:0], 1'b0};
        end
        it_d = it_q + 5'd1;
        if (it_q == 5'(tto_pkg::DIST_W - 1)) begin
          dist_we = 1'b1;
          if (CW'(b_q) == n_q - CW'(1)) begin
            b_d = '0;
            a_d = a_q + IW'(1);
            if (CW'(a_q) == n_q - CW'(1)) p_d = '0;
          end else begin
            b_d = b_q + IW'(1);
          end
        end
      end
      tto_pkg::S_INIT: begin
        tour_we    = 1'b1;
        tour_waddr = p_q;
        tour_wdata = p_q;
        p_d        = p_q + IW'(1);
        if (CW'(p_q) == n_q - CW'(1)) begin
          // Score the identity order: that sets the starting length.
          p_d     = '0;
          acc_d   = '0;
          first_d = 1'b1;
          c_d     = tto_pkg::RC_IDENT;
        end
      end
      tto_pkg::S_EV_ADDR: begin
        tour_raddr = map_pos(c_q, i_q, j_q, k_q, p_q, n_q);
      end
      tto_pkg::S_EV_TOUR: begin
        prev_d     = tour_rdata_q;
        dist_raddr = {prev_q, tour_rdata_q};
        if (p_q == '0) p_d = p_q + IW'(1);
      end
      tto_pkg::S_EV_DIST: begin
        acc_d = acc_sat;
        p_d   = p_q + IW'(1);
      end
      tto_pkg::S_EV_DONE: begin
        p_d   = '0;
        acc_d = '0;
        if (first_q) begin
          best_d     = acc_q;
          first_d    = 1'b0;
          improved_d = 1'b0;
          i_d = IW'(1); j_d = IW'(2); k_d = IW'(3); c_d = tto_pkg::RC_IDENT;
        end else begin
          if (better) begin
            best_d     = acc_q;
            improved_d = 1'b1;
            bi_d = i_q; bj_d = j_q; bk_d = k_q; bc_d = c_q;
          end
          if (c_q != tto_pkg::RC_ROTATE) begin
            c_d = tto_pkg::recon_e'(c_q + 3'd1);
          end else begin
            c_d = tto_pkg::RC_IDENT;
            if (CW'(k_q) != n_q - CW'(2)) begin
              k_d = k_q + IW'(1);
            end else if (CW'(j_q) != n_q - CW'(4)) begin
              j_d = j_q + IW'(1);
              k_d = j_q + IW'(2);
            end else if (CW'(i_q) != n_q - CW'(5)) begin
              i_d = i_q + IW'(1);
              j_d = i_q + IW'(2);
              k_d = i_q + IW'(3);
            end
          end
        end
      end
      tto_pkg::S_RB_ADDR: begin
        tour_raddr = map_pos(bc_q, bi_q, bj_q, bk_q, p_q, n_q);
      end
      tto_pkg::S_RB_WR: begin
        cand_we = 1'b1;
        p_d     = (CW'(p_q) == n_q - CW'(1)) ? '0 : p_q + IW'(1);
      end
      tto_pkg::S_CB_ADDR: begin
      end
      tto_pkg::S_CB_WR: begin
        tour_we    = 1'b1;
        tour_waddr = p_q;
        tour_wdata = cand_rdata_q;
        p_d        = p_q + IW'(1);
        if (CW'(p_q) == n_q - CW'(1)) begin
          // New pass from the adopted tour.
          p_d        = '0;
          acc_d      = '0;
          improved_d = 1'b0;
          i_d = IW'(1); j_d = IW'(2); k_d = IW'(3); c_d = tto_pkg::RC_IDENT;
        end
      end
      tto_pkg::S_EM_ADDR: begin
        tour_raddr = p_q;
      end
      tto_pkg::S_EM_SEND: begin
        valid_d              = 1'b1;
        result_d.city_index  = tto_pkg::CITY_W'(tour_rdata_q);
        result_d.path_length = best_q;
        result_d.last_city   = (CW'(p_q) == n_q - CW'(1));
        p_d                  = p_q + IW'(1);
        if (CW'(p_q) == n_q - CW'(1)) count_d = '0;
      end
      default: begin
      end
    endcase
  end

  // Memories
  always_ff @(posedge clk_i) begin
    if (point_we) begin
      point_mem[count_q[IW-1:0]] <= {item_i.x_coord, item_i.y_coord};
    end
    pa_q <= point_mem[a_q];
    pb_q <= point_mem[b_q];
  end

  always_ff @(posedge clk_i) begin
    if (dist_we) dist_mem[{a_q, b_q}] <= root_d;
    dist_rdata_q <= dist_mem[dist_raddr];
  end

  always_ff @(posedge clk_i) begin
    if (tour_we) tour_mem[tour_waddr] <= tour_wdata;
    tour_rdata_q <= tour_mem[tour_raddr];
  end

  always_ff @(posedge clk_i) begin
    if (cand_we) cand_mem[p_q] <= tour_rdata_q;
    cand_rdata_q <= cand_mem[p_q];
  end

  // Datapath registers
  always_ff @(posedge clk_i) begin
    ady_q  <= ady_d;
    sum_q  <= sum_d;
    rad_q  <= rad_d;
    rem_q  <= rem_d;
    root_q <= root_d;
    prev_q <= prev_d;
    acc_q  <= acc_d;
    bi_q   <= bi_d;
    bj_q   <= bj_d;
    bk_q   <= bk_d;
    bc_q   <= bc_d;
    result_q <= result_d;
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= tto_pkg::S_IDLE;
      count_q    <= '0;
      n_q        <= '0;
      a_q        <= '0;
      b_q        <= '0;
      p_q        <= '0;
      i_q        <= '0;
      j_q        <= '0;
      k_q        <= '0;
      c_q        <= tto_pkg::RC_IDENT;
      it_q       <= '0;
      first_q    <= 1'b0;
      improved_q <= 1'b0;
      best_q     <= '0;
      valid_q    <= 1'b0;
    end else begin
      state_q    <= state_d;
      count_q    <= count_d;
      n_q        <= n_d;
      a_q        <= a_d;
      b_q        <= b_d;
      p_q        <= p_d;
      i_q        <= i_d;
      j_q        <= j_d;
      k_q        <= k_d;
      c_q        <= c_d;
      it_q       <= it_d;
      first_q    <= first_d;
      improved_q <= improved_d;
      best_q     <= best_d;
      valid_q    <= valid_d;
    end
  end

  assign result_valid_o = valid_q;
  assign result_o       = result_q;

  // Assertions
  `TTO_ASSERT_NEXT(a_last_starts_run, accept && item_i.last_point, busy,
                   "last point did not start a run")
  `TTO_ASSERT_NOW(a_strobe_in_run, result_valid_o && !result_o.last_city, busy,
                  "result strobe outside a run")
  `TTO_ASSERT_NOW(a_best_monotonic,
                  $past(state_q) == tto_pkg::S_EV_DONE && !$past(first_q),
                  best_q <= $past(best_q), "best length grew during search")
  `TTO_ASSERT_NOW(a_count_bounded, 1'b1, count_q <= CW'(tto_pkg::MAX_POINTS),
                  "point count exceeds store depth")

endmodule

// ----- sim/tto_checker.sv -----
// Checker for the 3-opt path improver: tracks loaded points, predicts tours, compares results.
`timescale 1ns / 1ps
module tto_checker (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start,
  input  logic          busy,
  input  tto_pkg::in_t  item_i,
  input  logic          result_valid_o,
  input  tto_pkg::out_t result_o,
  output int            fail_count,
  output int            pending
);

  localparam int unsigned CAP = tto_pkg::MAX_POINTS;

  logic [31:0]     held_pts [CAP];
  int unsigned     held_count;
  longint unsigned dist_q8 [CAP][CAP];
  int              cur_tour [CAP];
  int              best_tour [CAP];
  int              cand_tour [CAP];
  tto_pkg::out_t   tour_q [$];

  function automatic longint unsigned int_sqrt(longint unsigned v);
    longint unsigned r;
    longint unsigned b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  // Open-path length, saturating.
  function automatic longint unsigned open_length(input int t [CAP], input int n);
    longint unsigned s;
    s = 0;
    for (int p = 0; p + 1 < n; p++) begin
      s += dist_q8[t[p]][t[p+1]];
      if (s > tto_pkg::LEN_MAX) return tto_pkg::LEN_MAX;
    end
    return s;
  endfunction

  task automatic put_seg(inout int pos, input int lo, input int hi, input bit rev);
    for (int q = 0; q < hi - lo; q++)
      cand_tour[pos + q] = cur_tour[rev ? hi - 1 - q : lo + q];
    pos += hi - lo;
  endtask

  task automatic predict_tour();
    int              n;
    int              pos;
    bit              improved;
    longint unsigned best_len;
    longint unsigned len;
    longint signed   dx;
    longint signed   dy;
    tto_pkg::out_t   res;
    n = held_count;
    for (int a = 0; a < n; a++)
      for (int b = 0; b < n; b++) begin
        dx = longint'(held_pts[a][31:16]) - longint'(held_pts[b][31:16]);
        dy = longint'(held_pts[a][15:0]) - longint'(held_pts[b][15:0]);
        dist_q8[a][b] = int_sqrt((dx * dx + dy * dy) << 16);
      end
    for (int p = 0; p < CAP; p++) cur_tour[p] = p;
    best_len = open_length(cur_tour, n);
    if (n >= tto_pkg::MIN_OPT_POINTS) begin
      best_tour = cur_tour;
      improved  = 1'b1;
      while (improved) begin
        improved = 1'b0;
        for (int i = 1; i < n - 4; i++)
          for (int j = i + 1; j < n - 3; j++)
            for (int k = j + 1; k < n - 1; k++)
              for (int c = 0; c < 8; c++) begin
                pos = 0;
                put_seg(pos, 0, i, 1'b0);
                case (tto_pkg::recon_e'(c))
                  tto_pkg::RC_IDENT: begin
                    put_seg(pos, i, j, 1'b0); put_seg(pos, j, k, 1'b0); put_seg(pos, k, n, 1'b0);
                  end
                  tto_pkg::RC_REV2: begin
                    put_seg(pos, i, j, 1'b1); put_seg(pos, j, k, 1'b0); put_seg(pos, k, n, 1'b0);
                  end
                  tto_pkg::RC_REV3: begin
                    put_seg(pos, i, j, 1'b0); put_seg(pos, j, k, 1'b1); put_seg(pos, k, n, 1'b0);
                  end
                  tto_pkg::RC_REV23: begin
                    put_seg(pos, i, j, 1'b1); put_seg(pos, j, k, 1'b1); put_seg(pos, k, n, 1'b0);
                  end
                  tto_pkg::RC_SWAP: begin
                    put_seg(pos, j, k, 1'b0); put_seg(pos, i, j, 1'b0); put_seg(pos, k, n, 1'b0);
                  end
                  tto_pkg::RC_SWAP_REV3: begin
                    put_seg(pos, j, k, 1'b1); put_seg(pos, i, j, 1'b0); put_seg(pos, k, n, 1'b0);
                  end
                  tto_pkg::RC_MOVE4: begin
                    put_seg(pos, i, j, 1'b0); put_seg(pos, k, n, 1'b0); put_seg(pos, j, k, 1'b0);
                  end
                  default: begin
                    put_seg(pos, k, n, 1'b0); put_seg(pos, j, k, 1'b0); put_seg(pos, i, j, 1'b0);
                  end
                endcase
                len = open_length(cand_tour, n);
                if (len < best_len) begin
                  best_len  = len;
                  best_tour = cand_tour;
                  improved  = 1'b1;
                end
              end
        if (improved) cur_tour = best_tour;
      end
    end
    for (int p = 0; p < n; p++) begin
      res.city_index  = cur_tour[p][tto_pkg::CITY_W-1:0];
      res.path_length = best_len[tto_pkg::LEN_W-1:0];
      res.last_city   = (p + 1 == n);
      tour_q = {tour_q, res};
    end
  endtask

  task automatic report_mismatch(input string what);
    $display("%0t checker: %s", $realtime, what);
    fail_count++;
  endtask

  always @(posedge clk_i) begin
    tto_pkg::out_t want;
    if (rst_ni && result_valid_o) begin
      if (tour_q.size() == 0) begin
        report_mismatch($sformatf("unexpected result city=%0d", result_o.city_index));
      end else begin
        want = tour_q.pop_front();
        if (result_o.city_index !== want.city_index)
          report_mismatch($sformatf("city_index %0d, want %0d",
                                    result_o.city_index, want.city_index));
        if (result_o.path_length !== want.path_length)
          report_mismatch($sformatf("path_length %0d, want %0d",
                                    result_o.path_length, want.path_length));
        if (result_o.last_city !== want.last_city)
          report_mismatch($sformatf("last_city %0b, want %0b",
                                    result_o.last_city, want.last_city));
      end
    end
    if (rst_ni && start && !busy) begin
      if (held_count < CAP) begin
        held_pts[held_count] = {item_i.x_coord, item_i.y_coord};
        held_count++;
      end
      if (item_i.last_point) begin
        predict_tour();
        held_count = 0;
      end
    end
    pending = tour_q.size();
  end

endmodule

// ----- sim/testbench.sv -----
// Testbench top for the 3-opt path improver: point sets as stimulus, verdict at the end.
`timescale 1ns / 1ps
module testbench;

  logic          clk_i = 1'b0;
  logic          rst_ni = 1'b0;
  logic          start = 1'b0;
  logic          busy;
  tto_pkg::in_t  item_i = '0;
  logic          result_valid_o;
  tto_pkg::out_t result_o;
  int            fail_count;
  int            pending;
  int            sent_points;

  always #2 clk_i = ~clk_i;

  tsp_three_opt_path_improver u_top (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .item_i         (item_i),
    .result_valid_o (result_valid_o),
    .result_o       (result_o)
  );

  tto_checker u_checker (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .item_i         (item_i),
    .result_valid_o (result_valid_o),
    .result_o       (result_o),
    .fail_count     (fail_count),
    .pending        (pending)
  );

  // Mostly back to back, sometimes short gaps, rarely a long one.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(99);
    if (r < 65) return 0;
    if (r < 95) return $urandom_range(3, 1);
    return $urandom_range(40, 8);
  endfunction

  // Called at a falling edge; returns at a falling edge. Start is raised at
  // the start of each step and lowered again only for a gap, otherwise left high.
  task automatic send_point(input logic [15:0] x, input logic [15:0] y, input bit last);
    int gap;
    start  <= 1'b1;
    item_i <= '{x_coord: x, y_coord: y, last_point: last};
    do @(posedge clk_i); while (busy);
    @(negedge clk_i);
    sent_points++;
    gap = pick_gap();
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
  endtask

  // One whole set; mode 0 full range, 1 tight cluster, 2 all coincident.
  task automatic send_set(input int n, input int mode);
    logic [15:0] x;
    logic [15:0] y;
    logic [15:0] bx;
    logic [15:0] by;
    bx = $urandom;
    by = $urandom;
    for (int p = 0; p < n; p++) begin
      case (mode)
        0: begin x = $urandom; y = $urandom; end
        1: begin x = bx ^ 16'($urandom_range(31)); y = by ^ 16'($urandom_range(31)); end
        default: begin x = bx; y = by; end
      endcase
      send_point(x, y, p == n - 1);
    end
  endtask

  initial begin
    #200_000_000;
    $display("tb: failure");
    $finish;
  end

  initial begin
    sent_points = 0;
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Single point at the top corner: a one-city tour of length zero.
    send_point(16'hFFFF, 16'hFFFF, 1'b1);
    // Four corners, fewer than ten points: identity order, two diagonals and a side.
    send_point(16'h0000, 16'h0000, 1'b0);
    send_point(16'hFFFF, 16'hFFFF, 1'b0);
    send_point(16'h0000, 16'hFFFF, 1'b0);
    send_point(16'hFFFF, 16'h0000, 1'b1);
    // Two coincident points.
    send_point(16'h1234, 16'h1234, 1'b0);
    send_point(16'h1234, 16'h1234, 1'b1);
    // Ten scattered points: smallest set that runs the search.
    send_set(10, 0);

    while (sent_points < 150) begin
      if ($urandom_range(99) < 75) send_set($urandom_range(9, 1), $urandom_range(2));
      else send_set($urandom_range(12, 10), $urandom_range(99) < 85 ? 0 : 1);
    end
    start <= 1'b0;

    while (pending != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

// ----- files.f -----
+incdir+design
design/tto_pkg.sv
design/tsp_three_opt_path_improver.sv
sim/tto_checker.sv
sim/testbench.sv
